[rtl/aabb_cr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_cr_pkg
// Shared types and constants of the box collision response unit: field
// widths, contact side codes and the result record.
// ----------------------------------------------------------------------------

package aabb_cr_pkg;

  // port widths of coordinates, velocities and sizes
  localparam int unsigned FieldW = 32;
  localparam int unsigned SizeW  = 31;

  // contact side of the moving box
  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_BOTTOM = 2'd3
  } side_e;

  // one finished result
  typedef struct packed {
    logic              hit;
    side_e             side;
    logic [FieldW-1:0] vel_x;
    logic [FieldW-1:0] vel_y;
    logic [FieldW-1:0] push_x;
    logic [FieldW-1:0] push_y;
  } result_t;

endpackage : aabb_cr_pkg
`default_nettype wire

[rtl/aabb_cr_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_cr_core
// Combinational datapath: overlap test, contact side by smallest overlap,
// velocity reflection and push-out position, all saturated to CoordW bits.
// ----------------------------------------------------------------------------

module aabb_cr_core #(
  parameter int unsigned CoordW = 32
) (
  input  wire logic [aabb_cr_pkg::FieldW-1:0] a_x_i,
  input  wire logic [aabb_cr_pkg::FieldW-1:0] a_y_i,
  input  wire logic [aabb_cr_pkg::SizeW-1:0]  a_width_i,
  input  wire logic [aabb_cr_pkg::SizeW-1:0]  a_height_i,
  input  wire logic [aabb_cr_pkg::FieldW-1:0] a_vel_x_i,
  input  wire logic [aabb_cr_pkg::FieldW-1:0] a_vel_y_i,
  input  wire logic [aabb_cr_pkg::FieldW-1:0] b_x_i,
  input  wire logic [aabb_cr_pkg::FieldW-1:0] b_y_i,
  input  wire logic [aabb_cr_pkg::SizeW-1:0]  b_width_i,
  input  wire logic [aabb_cr_pkg::SizeW-1:0]  b_height_i,
  output aabb_cr_pkg::result_t                res_o
);

  // two guard bits cover a coordinate plus a size minus a coordinate
  localparam int unsigned OW = CoordW + 2;

  // clamp to the CoordW-bit signed range, then sign-extend to the port width
  function automatic logic [aabb_cr_pkg::FieldW-1:0] sat_out(input logic signed [OW-1:0] v);
    logic signed [CoordW-1:0] r;
    logic                     fits;
    fits = (v[OW-1:CoordW-1] == {(OW-CoordW+1){1'b0}}) ||
           (v[OW-1:CoordW-1] == {(OW-CoordW+1){1'b1}});
    if (fits) begin
      r = v[CoordW-1:0];
    end else if (v[OW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return aabb_cr_pkg::FieldW'(r);
  endfunction

  logic signed [CoordW-1:0] ax, ay, vx, vy, bx, by;
  logic        [CoordW-2:0] aw, ah, bw, bh;
  logic signed [OW-1:0]     ax_e, ay_e, vx_e, vy_e, bx_e, by_e;
  logic signed [OW-1:0]     aw_e, ah_e, bw_e, bh_e;
  logic signed [OW-1:0]     ov_l, ov_r, ov_t, ov_b;
  logic signed [OW-1:0]     min_lr, min_tb;
  logic                     pick_r, pick_b, pick_tb;
  aabb_cr_pkg::side_e       side;
  logic signed [OW-1:0]     nvx, nvy, px, py;

  // effective coordinates and sizes from the low bits of each field
  assign ax = a_x_i[CoordW-1:0];
  assign ay = a_y_i[CoordW-1:0];
  assign vx = a_vel_x_i[CoordW-1:0];
  assign vy = a_vel_y_i[CoordW-1:0];
  assign bx = b_x_i[CoordW-1:0];
  assign by = b_y_i[CoordW-1:0];
  assign aw = a_width_i[CoordW-2:0];
  assign ah = a_height_i[CoordW-2:0];
  assign bw = b_width_i[CoordW-2:0];
  assign bh = b_height_i[CoordW-2:0];

  assign ax_e = OW'(ax);
  assign ay_e = OW'(ay);
  assign vx_e = OW'(vx);
  assign vy_e = OW'(vy);
  assign bx_e = OW'(bx);
  assign by_e = OW'(by);
  assign aw_e = signed'(OW'(aw));
  assign ah_e = signed'(OW'(ah));
  assign bw_e = signed'(OW'(bw));
  assign bh_e = signed'(OW'(bh));

  // penetration depth on each side
  assign ov_l = ax_e + aw_e - bx_e;
  assign ov_r = bx_e + bw_e - ax_e;
  assign ov_t = ay_e + ah_e - by_e;
  assign ov_b = by_e + bh_e - ay_e;

  // smallest overlap, ties go to the earlier side
  assign pick_r  = ov_r < ov_l;
  assign min_lr  = pick_r ? ov_r : ov_l;
  assign pick_b  = ov_b < ov_t;
  assign min_tb  = pick_b ? ov_b : ov_t;
  assign pick_tb = min_tb < min_lr;

  always_comb begin
    if (pick_tb) begin
      side = pick_b ? aabb_cr_pkg::SIDE_BOTTOM : aabb_cr_pkg::SIDE_TOP;
    end else begin
      side = pick_r ? aabb_cr_pkg::SIDE_RIGHT : aabb_cr_pkg::SIDE_LEFT;
    end
  end

  // reflect velocity and push the box out on the contact side
  always_comb begin
    nvx = vx_e;
    nvy = vy_e;
    px  = ax_e;
    py  = ay_e;
    unique case (side)
      aabb_cr_pkg::SIDE_LEFT: begin
        nvx = -vx_e;
        px  = bx_e - aw_e;
      end
      aabb_cr_pkg::SIDE_RIGHT: begin
        nvx = -vx_e;
        px  = bx_e + bw_e;
      end
      aabb_cr_pkg::SIDE_TOP: begin
        nvy = -vy_e;
        py  = by_e - ah_e;
      end
      default: begin
        nvy = -vy_e;
        py  = by_e + bh_e;
      end
    endcase
  end

  // hit when both axes overlap, touching edges included
  assign res_o.hit    = !ov_l[OW-1] && !ov_r[OW-1] && !ov_t[OW-1] && !ov_b[OW-1];
  assign res_o.side   = side;
  assign res_o.vel_x  = sat_out(nvx);
  assign res_o.vel_y  = sat_out(nvy);
  assign res_o.push_x = sat_out(px);
  assign res_o.push_y = sat_out(py);

endmodule : aabb_cr_core
`default_nettype wire

[rtl/aabb_collision_response_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_collision_response_unit
// Box-versus-box collision response: hit test, contact side, reflected
// velocity and push-out position for one box pair per transaction.
// ----------------------------------------------------------------------------
// A box pair is taken whenever start_i is high; busy_o stays low, so a new
// transaction can be issued in every cycle. Each result appears on the
// output ports with done_o after passing the input register and then the
// overlap, compare and saturate datapath into the result register. done_o
// is a single-cycle strobe and the receiver cannot stall it, so it must
// capture results as they come. Results leave in issue order. COORD_BITS
// sets the effective signed width of coordinates and velocities (capped at
// 32); sizes use one bit fewer.

module aabb_collision_response_unit #(
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] a_x_i,
  input  wire logic [31:0] a_y_i,
  input  wire logic [30:0] a_width_i,
  input  wire logic [30:0] a_height_i,
  input  wire logic [31:0] a_vel_x_i,
  input  wire logic [31:0] a_vel_y_i,
  input  wire logic [31:0] b_x_i,
  input  wire logic [31:0] b_y_i,
  input  wire logic [30:0] b_width_i,
  input  wire logic [30:0] b_height_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [1:0]       side_o,
  output logic [31:0]      new_vel_x_o,
  output logic [31:0]      new_vel_y_o,
  output logic [31:0]      push_x_o,
  output logic [31:0]      push_y_o
);

  localparam int unsigned CW = (COORD_BITS < 32) ? COORD_BITS : 32;

  logic                 accept;
  logic                 in_vld_q;
  logic                 out_vld_q;
  logic [31:0]          a_x_q, a_y_q, a_vel_x_q, a_vel_y_q, b_x_q, b_y_q;
  logic [30:0]          a_width_q, a_height_q, b_width_q, b_height_q;
  aabb_cr_pkg::result_t res_d, res_q;
  logic signed [CW-1:0] ax_cw, ay_cw, vx_cw, vy_cw;
  logic [31:0]          ax_ext, ay_ext, vx_ext, vy_ext;

  // never stalls: one transaction per cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_x_q      <= a_x_i;
      a_y_q      <= a_y_i;
      a_width_q  <= a_width_i;
      a_height_q <= a_height_i;
      a_vel_x_q  <= a_vel_x_i;
      a_vel_y_q  <= a_vel_y_i;
      b_x_q      <= b_x_i;
      b_y_q      <= b_y_i;
      b_width_q  <= b_width_i;
      b_height_q <= b_height_i;
    end
  end

  // collision datapath
  aabb_cr_core #(
    .CoordW (CW)
  ) u_core (
    .a_x_i      (a_x_q),
    .a_y_i      (a_y_q),
    .a_width_i  (a_width_q),
    .a_height_i (a_height_q),
    .a_vel_x_i  (a_vel_x_q),
    .a_vel_y_i  (a_vel_y_q),
    .b_x_i      (b_x_q),
    .b_y_i      (b_y_q),
    .b_width_i  (b_width_q),
    .b_height_i (b_height_q),
    .res_o      (res_d)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o      = out_vld_q;
  assign hit_o       = res_q.hit;
  assign side_o      = res_q.side;
  assign new_vel_x_o = res_q.vel_x;
  assign new_vel_y_o = res_q.vel_y;
  assign push_x_o    = res_q.push_x;
  assign push_y_o    = res_q.push_y;

  // untouched axis values, for the checks below
  assign ax_cw  = a_x_q[CW-1:0];
  assign ay_cw  = a_y_q[CW-1:0];
  assign vx_cw  = a_vel_x_q[CW-1:0];
  assign vy_cw  = a_vel_y_q[CW-1:0];
  assign ax_ext = 32'(ax_cw);
  assign ay_ext = 32'(ay_cw);
  assign vx_ext = 32'(vx_cw);
  assign vy_ext = 32'(vy_cw);

  // every captured pair yields a result in the next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |=> done_o)
    else $error("captured transaction produced no result");

  // no result without a captured pair
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_vld_q))
    else $error("result strobe without a transaction");

  // a horizontal contact leaves the vertical motion and position alone
  a_horiz_keeps_y : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (side_o == aabb_cr_pkg::SIDE_LEFT || side_o == aabb_cr_pkg::SIDE_RIGHT)
    |-> new_vel_y_o == $past(vy_ext) && push_y_o == $past(ay_ext))
    else $error("horizontal contact changed the y axis");

  // a vertical contact leaves the horizontal motion and position alone
  a_vert_keeps_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (side_o == aabb_cr_pkg::SIDE_TOP || side_o == aabb_cr_pkg::SIDE_BOTTOM)
    |-> new_vel_x_o == $past(vx_ext) && push_x_o == $past(ax_ext))
    else $error("vertical contact changed the x axis");

endmodule : aabb_collision_response_unit
`default_nettype wire
